>>> rtl/core/dvl_pkg.sv
// Shared constants, codes and types for the dq voltage limit and inverse transform core.
`timescale 1ns / 1ps
package dvl_pkg;

    localparam int VOLTAGE_WIDTH = 16;
    localparam int ANGLE_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int COEF_WIDTH = 16;

    localparam logic [15:0] COEF_A = 16'd25736;
    localparam logic [15:0] COEF_B = 16'd10512;
    localparam logic [15:0] COEF_C = 16'd1160;
    localparam logic [15:0] HALF_SQRT3_Q15 = 16'd28378;
    localparam logic [COEF_WIDTH-1:0] FILTER_COEF_RESET = 16'hFFFF;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_LIMIT = 3'd0,
        CFG_FILTER_EN = 3'd1,
        CFG_FILTER_COEF = 3'd2,
        CFG_ZERO_EN = 3'd3,
        CFG_ZERO_THR = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic filter_en;
        logic [COEF_WIDTH-1:0] filter_coef;
        logic zero_en;
    } t_back_cfg;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MDD, ST_MQQ, ST_MLL, ST_CMP, ST_SQRT, ST_MDL, ST_MQL, ST_DIVI,
        ST_DIV, ST_X2, ST_T1, ST_T2, ST_T3, ST_T4, ST_AB1, ST_AB2, ST_AB3, ST_AB4,
        ST_AB5, ST_PB, ST_PC, ST_FM, ST_FU, ST_DONE
    } t_state;

endpackage

>>> rtl/core/dvl_if.sv
// Handshake interfaces for the input and result words of the core.
`timescale 1ns / 1ps
interface dvl_in_if #(
    parameter int VW = 16,
    parameter int AW = 16
);
    logic valid;
    logic ready;
    logic signed [VW-1:0] d_voltage;
    logic signed [VW-1:0] q_voltage;
    logic [AW-1:0] rotor_angle;
    logic [VW-2:0] bus_voltage;
    logic direct_path;

    modport source (output valid, d_voltage, q_voltage, rotor_angle, bus_voltage,
        direct_path, input ready);
    modport sink (input valid, d_voltage, q_voltage, rotor_angle, bus_voltage,
        direct_path, output ready);
endinterface

interface dvl_out_if #(
    parameter int VW = 16
);
    logic valid;
    logic ready;
    logic signed [VW-1:0] phase_a_voltage;
    logic signed [VW-1:0] phase_b_voltage;
    logic signed [VW-1:0] phase_c_voltage;
    logic signed [VW-1:0] alpha_voltage;
    logic signed [VW-1:0] beta_voltage;
    logic [VW-2:0] vector_magnitude;
    logic zero_vector;
    logic direct_path_echo;

    modport source (output valid, phase_a_voltage, phase_b_voltage, phase_c_voltage,
        alpha_voltage, beta_voltage, vector_magnitude, zero_vector, direct_path_echo,
        input ready);
    modport sink (input valid, phase_a_voltage, phase_b_voltage, phase_c_voltage,
        alpha_voltage, beta_voltage, vector_magnitude, zero_vector, direct_path_echo,
        output ready);
endinterface

>>> rtl/core/dvl_front.sv
// Front end: accepts input words, resolves the voltage limit and packs them for the queue.
`timescale 1ns / 1ps
module dvl_front
    import dvl_pkg::*;
#(
    parameter int VW = VOLTAGE_WIDTH,
    parameter int AW = ANGLE_WIDTH,
    localparam int FW = 3 * VW + AW
) (
    dvl_in_if.sink i_in,
    input logic [VW-2:0] i_limit,
    input logic i_full,
    output logic o_push,
    output logic [FW-1:0] o_word
);

    logic [VW-2:0] lim;

    assign lim = (i_limit < i_in.bus_voltage) ? i_limit : i_in.bus_voltage;
    assign i_in.ready = !i_full;
    assign o_push = i_in.valid && !i_full;
    assign o_word = {i_in.d_voltage, i_in.q_voltage, i_in.rotor_angle, lim,
        i_in.direct_path};

endmodule

>>> rtl/core/dvl_queue.sv
// Two-entry queue between the front end and the sequencer.
`timescale 1ns / 1ps
module dvl_queue #(
    parameter int W = 8
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_push,
    input logic [W-1:0] i_word,
    input logic i_pop,
    output logic o_full,
    output logic o_valid,
    output logic [W-1:0] o_word
);

    logic [W-1:0] r_mem [2];
    logic r_wr;
    logic r_rd;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0;
            r_rd <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_word = r_mem[r_rd];

endmodule

>>> rtl/core/dvl_back.sv
// Back end: sequencer with one shared multiplier, root and divider steps, transforms and filter.
`timescale 1ns / 1ps
module dvl_back
    import dvl_pkg::*;
#(
    parameter int VW = VOLTAGE_WIDTH,
    parameter int AW = ANGLE_WIDTH,
    localparam int FW = 3 * VW + AW
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic [FW-1:0] i_word,
    output logic o_pop,
    input t_back_cfg i_cfg,
    input logic [VW-2:0] i_zero_thr,
    dvl_out_if.source o_out
);

    localparam int OW = (VW + 2 > 18) ? VW + 2 : 18;
    localparam int PW = 2 * OW;
    localparam int CNTW = $clog2(2 * VW + 1);
    localparam logic [CNTW-1:0] SQ_LAST = CNTW'(VW - 1);
    localparam logic [CNTW-1:0] DV_LAST = CNTW'(2 * VW - 1);
    localparam logic signed [PW-1:0] ONE = 1;
    localparam logic signed [PW-1:0] VHI = (ONE <<< (VW - 1)) - ONE;
    localparam logic signed [PW-1:0] VLO = -VHI - ONE;

    function automatic logic signed [PW-1:0] rnd_sh(input logic signed [PW-1:0] v,
                                                    input int k);
        rnd_sh = (v + (ONE <<< (k - 1))) >>> k;
    endfunction

    function automatic logic signed [VW-1:0] sat_v(input logic signed [PW-1:0] v);
        if (v > VHI) begin
            sat_v = VHI[VW-1:0];
        end else if (v < VLO) begin
            sat_v = VLO[VW-1:0];
        end else begin
            sat_v = v[VW-1:0];
        end
    endfunction

    t_state r_state;
    t_state n_state;

    logic signed [OW-1:0] mul_a;
    logic signed [OW-1:0] mul_b;
    logic signed [PW-1:0] r_prod;

    logic signed [VW-1:0] r_d;
    logic signed [VW-1:0] r_q;
    logic [AW-1:0] r_ang;
    logic [VW-2:0] r_lim;
    logic r_path;
    logic signed [PW-1:0] r_m2;
    logic r_scale;
    logic [2*VW-1:0] r_rad;
    logic [VW-1:0] r_root;
    logic [VW+2:0] r_rem;
    logic [CNTW-1:0] r_cnt;
    logic [2*VW-1:0] r_nd;
    logic [2*VW-1:0] r_nq;
    logic [VW:0] r_rd;
    logic [VW:0] r_rq;
    logic r_sel;
    logic [15:0] r_x2;
    logic signed [17:0] r_sn;
    logic signed [17:0] r_cs;
    logic signed [PW-1:0] r_acc;
    logic signed [VW-1:0] r_alpha;
    logic signed [VW-1:0] r_beta;
    logic signed [VW-1:0] r_pa;
    logic signed [VW-1:0] r_pb;
    logic signed [VW-1:0] r_pc;
    logic signed [VW-1:0] r_ya;
    logic signed [VW-1:0] r_yb;
    logic signed [VW-1:0] r_yc;
    logic r_seeded;
    logic [1:0] r_fidx;
    logic [VW-2:0] r_cmd;
    logic r_ov;

    logic [1:0] quad_s;
    logic [29:0] ph30;
    logic [16:0] x_s;
    logic [VW+2:0] sq_in;
    logic [VW+2:0] sq_trial;
    logic sq_ge;
    logic [VW:0] dd_in;
    logic [VW:0] dq_in;
    logic dd_ge;
    logic dq_ge;
    logic signed [OW-1:0] abs_d;
    logic signed [OW-1:0] abs_q;
    logic signed [VW-1:0] f_x;
    logic signed [VW-1:0] f_y;
    logic signed [VW-1:0] f_new;
    logic signed [PW-1:0] am;
    logic out_free;
    logic filter_run;

    assign quad_s = r_ang[AW-1:AW-2] + 2'(r_sel);
    assign ph30 = {r_ang[AW-3:0], {(32 - AW){1'b0}}};
    assign x_s = quad_s[0] ? (17'd32768 - 17'(ph30[29:15])) : 17'(ph30[29:15]);
    assign sq_in = {r_rem[VW:0], r_rad[2*VW-1:2*VW-2]};
    assign sq_trial = (VW + 3)'({r_root, 2'b01});
    assign sq_ge = (sq_in >= sq_trial);
    assign dd_in = {r_rd[VW-1:0], r_nd[2*VW-1]};
    assign dq_in = {r_rq[VW-1:0], r_nq[2*VW-1]};
    assign dd_ge = (dd_in >= {1'b0, r_root});
    assign dq_ge = (dq_in >= {1'b0, r_root});
    assign abs_d = r_d[VW-1] ? -OW'(r_d) : OW'(r_d);
    assign abs_q = r_q[VW-1] ? -OW'(r_q) : OW'(r_q);
    assign am = PW'(r_alpha) <<< 14;
    assign out_free = !r_ov || o_out.ready;
    assign filter_run = i_cfg.filter_en && r_seeded;

    always_comb begin
        case (r_fidx)
            2'd0: begin
                f_x = r_pa;
                f_y = r_ya;
            end
            2'd1: begin
                f_x = r_pb;
                f_y = r_yb;
            end
            default: begin
                f_x = r_pc;
                f_y = r_yc;
            end
        endcase
        f_new = sat_v(PW'(f_y) + rnd_sh(r_prod, 16));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_MDD;
                end
            end
            ST_MDD: n_state = ST_MQQ;
            ST_MQQ: n_state = ST_MLL;
            ST_MLL: n_state = ST_CMP;
            ST_CMP: n_state = ST_SQRT;
            ST_SQRT: begin
                if (r_cnt == SQ_LAST) begin
                    n_state = ST_MDL;
                end
            end
            ST_MDL: n_state = ST_MQL;
            ST_MQL: n_state = ST_DIVI;
            ST_DIVI: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == DV_LAST) begin
                    n_state = ST_X2;
                end
            end
            ST_X2: n_state = ST_T1;
            ST_T1: n_state = ST_T2;
            ST_T2: n_state = ST_T3;
            ST_T3: n_state = ST_T4;
            ST_T4: n_state = r_sel ? ST_AB1 : ST_X2;
            ST_AB1: n_state = ST_AB2;
            ST_AB2: n_state = ST_AB3;
            ST_AB3: n_state = ST_AB4;
            ST_AB4: n_state = ST_AB5;
            ST_AB5: n_state = ST_PB;
            ST_PB: n_state = ST_PC;
            ST_PC: n_state = filter_run ? ST_FM : ST_DONE;
            ST_FM: n_state = ST_FU;
            ST_FU: n_state = (r_fidx == 2'd2) ? ST_DONE : ST_FM;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        o_pop = 1'b0;
        case (r_state)
            ST_IDLE: o_pop = i_valid;
            ST_MDD: begin
                mul_a = OW'(r_d);
                mul_b = OW'(r_d);
            end
            ST_MQQ: begin
                mul_a = OW'(r_q);
                mul_b = OW'(r_q);
            end
            ST_MLL: begin
                mul_a = OW'(r_lim);
                mul_b = OW'(r_lim);
            end
            ST_MDL: begin
                mul_a = abs_d;
                mul_b = OW'(r_lim);
            end
            ST_MQL: begin
                mul_a = abs_q;
                mul_b = OW'(r_lim);
            end
            ST_X2: begin
                mul_a = OW'(x_s);
                mul_b = OW'(x_s);
            end
            ST_T1: begin
                mul_a = OW'(COEF_C);
                mul_b = OW'(r_prod[30:15]);
            end
            ST_T2: begin
                mul_a = OW'(COEF_B - r_prod[30:15]);
                mul_b = OW'(r_x2);
            end
            ST_T3: begin
                mul_a = OW'(COEF_A - r_prod[30:15]);
                mul_b = OW'(x_s);
            end
            ST_AB1: begin
                mul_a = OW'(r_d);
                mul_b = OW'(r_cs);
            end
            ST_AB2: begin
                mul_a = OW'(r_q);
                mul_b = OW'(r_sn);
            end
            ST_AB3: begin
                mul_a = OW'(r_d);
                mul_b = OW'(r_sn);
            end
            ST_AB4: begin
                mul_a = OW'(r_q);
                mul_b = OW'(r_cs);
            end
            ST_PB: begin
                mul_a = OW'(r_beta);
                mul_b = OW'(HALF_SQRT3_Q15);
            end
            ST_FM: begin
                mul_a = OW'(i_cfg.filter_coef);
                mul_b = OW'(f_x) - OW'(f_y);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            ST_IDLE: begin
                r_d <= i_word[FW-1 -: VW];
                r_q <= i_word[FW-VW-1 -: VW];
                r_ang <= i_word[VW+AW-1 -: AW];
                r_lim <= i_word[VW-1:1];
                r_path <= i_word[0];
            end
            ST_MQQ: r_m2 <= r_prod;
            ST_MLL: r_m2 <= r_m2 + r_prod;
            ST_CMP: begin
                r_scale <= (r_m2 > r_prod);
                r_rad <= r_m2[2*VW-1:0];
                r_root <= '0;
                r_rem <= '0;
                r_cnt <= '0;
            end
            ST_SQRT: begin
                r_rad <= {r_rad[2*VW-3:0], 2'b00};
                r_rem <= sq_ge ? (sq_in - sq_trial) : sq_in;
                r_root <= {r_root[VW-2:0], sq_ge};
                r_cnt <= r_cnt + CNTW'(1);
            end
            ST_MQL: r_nd <= r_prod[2*VW-1:0];
            ST_DIVI: begin
                r_nq <= r_prod[2*VW-1:0];
                r_rd <= '0;
                r_rq <= '0;
                r_cnt <= '0;
            end
            ST_DIV: begin
                r_rd <= dd_ge ? (dd_in - {1'b0, r_root}) : dd_in;
                r_rq <= dq_ge ? (dq_in - {1'b0, r_root}) : dq_in;
                r_nd <= {r_nd[2*VW-2:0], dd_ge};
                r_nq <= {r_nq[2*VW-2:0], dq_ge};
                r_cnt <= r_cnt + CNTW'(1);
                r_sel <= 1'b0;
                if (r_cnt == DV_LAST) begin
                    if (r_scale) begin
                        r_d <= r_d[VW-1] ? -$signed({r_nd[VW-2:0], dd_ge})
                                         : $signed({r_nd[VW-2:0], dd_ge});
                        r_q <= r_q[VW-1] ? -$signed({r_nq[VW-2:0], dq_ge})
                                         : $signed({r_nq[VW-2:0], dq_ge});
                        r_cmd <= r_lim;
                    end else begin
                        r_cmd <= r_root[VW-2:0];
                    end
                end
            end
            ST_T1: r_x2 <= r_prod[30:15];
            ST_T4: begin
                r_sel <= 1'b1;
                if (r_sel) begin
                    r_cs <= quad_s[1] ? -$signed({1'b0, r_prod[30:14]})
                                      : $signed({1'b0, r_prod[30:14]});
                end else begin
                    r_sn <= quad_s[1] ? -$signed({1'b0, r_prod[30:14]})
                                      : $signed({1'b0, r_prod[30:14]});
                end
            end
            ST_AB2: r_acc <= r_prod;
            ST_AB3: r_acc <= r_acc - r_prod;
            ST_AB4: begin
                r_alpha <= sat_v(rnd_sh(r_acc, 15));
                r_acc <= r_prod;
            end
            ST_AB5: r_beta <= sat_v(rnd_sh(r_acc + r_prod, 15));
            ST_PC: begin
                r_pa <= r_alpha;
                r_pb <= sat_v(rnd_sh(r_prod - am, 15));
                r_pc <= sat_v(rnd_sh(-am - r_prod, 15));
            end
            ST_FU: begin
                case (r_fidx)
                    2'd0: r_pa <= f_new;
                    2'd1: r_pb <= f_new;
                    default: r_pc <= f_new;
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov <= 1'b0;
            r_seeded <= 1'b0;
            r_ya <= '0;
            r_yb <= '0;
            r_yc <= '0;
            r_fidx <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_PC) begin
                r_fidx <= 2'd0;
            end
            if (r_state == ST_FU) begin
                r_fidx <= r_fidx + 2'd1;
                case (r_fidx)
                    2'd0: r_ya <= f_new;
                    2'd1: r_yb <= f_new;
                    default: r_yc <= f_new;
                endcase
            end
            if (r_state == ST_DONE && out_free) begin
                r_ov <= 1'b1;
                if (!i_cfg.filter_en) begin
                    r_seeded <= 1'b0;
                end else if (!r_seeded) begin
                    r_seeded <= 1'b1;
                    r_ya <= r_pa;
                    r_yb <= r_pb;
                    r_yc <= r_pc;
                end
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            o_out.phase_a_voltage <= r_pa;
            o_out.phase_b_voltage <= r_pb;
            o_out.phase_c_voltage <= r_pc;
            o_out.alpha_voltage <= r_alpha;
            o_out.beta_voltage <= r_beta;
            o_out.vector_magnitude <= r_cmd;
            o_out.zero_vector <= i_cfg.zero_en && (r_cmd < i_zero_thr);
            o_out.direct_path_echo <= r_path;
        end
    end

    assign o_out.valid = r_ov;

endmodule

>>> rtl/core/dq_voltage_limit_inverse_park_clarke_core.sv
// Top level: configuration registers, front end, queue and sequencer of the core.
// Each word runs through the sequencer in turn: squares, compare, root, scaling divide,
// sine and cosine, transforms and, when the phase filter is seeded and running, the
// filter steps; the shared multiplier, the bit-per-cycle root and the two-word divider
// keep one word in the sequencer at a time; up to two more words wait in the queue.
// Reset is synchronous and active low; it clears configuration registers, filter state and queue.
`timescale 1ns / 1ps
module dq_voltage_limit_inverse_park_clarke_core
    import dvl_pkg::*;
#(
    parameter int VW = VOLTAGE_WIDTH,
    parameter int AW = ANGLE_WIDTH,
    localparam int CW = (VW - 1 > COEF_WIDTH) ? VW - 1 : COEF_WIDTH
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_cfg_we,
    input logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input logic [CW-1:0] i_cfg_data,
    dvl_in_if.sink i_in,
    dvl_out_if.source o_out
);

    localparam int FW = 3 * VW + AW;

    logic [VW-2:0] r_limit;
    logic r_filter_en;
    logic [COEF_WIDTH-1:0] r_filter_coef;
    logic r_zero_en;
    logic [VW-2:0] r_zero_thr;

    t_back_cfg back_cfg;
    logic push;
    logic pop;
    logic q_full;
    logic q_valid;
    logic [FW-1:0] f_word;
    logic [FW-1:0] q_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
            r_filter_en <= 1'b0;
            r_filter_coef <= FILTER_COEF_RESET;
            r_zero_en <= 1'b0;
            r_zero_thr <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LIMIT: r_limit <= i_cfg_data[VW-2:0];
                CFG_FILTER_EN: r_filter_en <= i_cfg_data[0];
                CFG_FILTER_COEF: r_filter_coef <= i_cfg_data[COEF_WIDTH-1:0];
                CFG_ZERO_EN: r_zero_en <= i_cfg_data[0];
                CFG_ZERO_THR: r_zero_thr <= i_cfg_data[VW-2:0];
                default: begin
                end
            endcase
        end
    end

    assign back_cfg = '{filter_en: r_filter_en, filter_coef: r_filter_coef,
                        zero_en: r_zero_en};

    dvl_front #(.VW(VW), .AW(AW)) u_front (
        .i_in(i_in),
        .i_limit(r_limit),
        .i_full(q_full),
        .o_push(push),
        .o_word(f_word)
    );

    dvl_queue #(.W(FW)) u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .i_word(f_word),
        .i_pop(pop),
        .o_full(q_full),
        .o_valid(q_valid),
        .o_word(q_word)
    );

    dvl_back #(.VW(VW), .AW(AW)) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .i_word(q_word),
        .o_pop(pop),
        .i_cfg(back_cfg),
        .i_zero_thr(r_zero_thr),
        .o_out(o_out)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push)
        else $error("Queue written while full.");

    a_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("Queue read while empty.");

    a_queue_fills_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && !pop && push) |=> q_full)
        else $error("Queue lost a word.");

endmodule

>>> tb/sv/tb_dq_voltage_limit_inverse_park_clarke_core.sv
// Self-checking testbench for the dq voltage limit and inverse Park/Clarke core.
`timescale 1ns / 1ps
module tb_dq_voltage_limit_inverse_park_clarke_core;
    import dvl_pkg::*;

    localparam int VW = VOLTAGE_WIDTH;
    localparam int AW = ANGLE_WIDTH;
    localparam int CW = (VW - 1 > COEF_WIDTH) ? VW - 1 : COEF_WIDTH;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED_INDEX = 3'd7;
    localparam int DRAIN_CYCLES = 120;
    localparam int PHASE_ITEMS = 215;

    typedef struct {
        logic signed [VW-1:0] d;
        logic signed [VW-1:0] q;
        logic [AW-1:0] angle;
        logic [VW-2:0] bus;
        logic direct;
    } t_cmd_word;

    typedef struct {
        logic signed [VW-1:0] pa;
        logic signed [VW-1:0] pb;
        logic signed [VW-1:0] pc;
        logic signed [VW-1:0] alpha;
        logic signed [VW-1:0] beta;
        logic [VW-2:0] vcmd;
        logic zero;
        logic direct;
    } t_phase_word;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [CW-1:0] i_cfg_data;

    dvl_in_if #(.VW(VW), .AW(AW)) cmd_ch ();
    dvl_out_if #(.VW(VW)) phase_ch ();

    dq_voltage_limit_inverse_park_clarke_core u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in(cmd_ch.sink),
        .o_out(phase_ch.source)
    );

    t_cmd_word pending_cmds[$];
    t_phase_word expected_phases[$];
    int send_idle_pct;
    int recv_idle_pct;
    bit cmd_taken;
    bit failed;

    longint lim_setting;
    bit filt_en;
    longint filt_k;
    bit zero_en;
    longint zero_thr;
    longint filt_y[3];
    bit filt_seeded;

    function automatic longint sat_volt(longint v);
        longint hi;
        hi = (longint'(1) <<< (VW - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint round_down(longint v, int k);
        return (v + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic longint floor_sqrt(longint v);
        longint res;
        longint bitv;
        res = 0;
        bitv = longint'(1) <<< 62;
        while (bitv > v) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >>> 1) + bitv;
            end else begin
                res = res >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    function automatic longint sine_q15(logic [31:0] ph);
        longint x;
        longint x2;
        longint t;
        longint s;
        x = ph[29:15];
        if (ph[30]) x = 32768 - x;
        x2 = (x * x) >>> 15;
        t = 10512 - ((1160 * x2) >>> 15);
        t = 25736 - ((t * x2) >>> 15);
        s = (t * x) >>> 14;
        return ph[31] ? -s : s;
    endfunction

    function automatic longint scale_to_limit(longint v, longint lim, longint mag);
        longint r;
        r = ((v < 0 ? -v : v) * lim) / mag;
        return v < 0 ? -r : r;
    endfunction

    function automatic t_phase_word predict_phases(t_cmd_word w);
        t_phase_word r;
        longint d;
        longint q;
        longint lim;
        longint m2;
        longint vcmd;
        longint mag;
        longint sn;
        longint cs;
        longint alpha;
        longint beta;
        longint ph[3];
        logic [31:0] phase;
        d = w.d;
        q = w.q;
        lim = (lim_setting < longint'(w.bus)) ? lim_setting : longint'(w.bus);
        m2 = d * d + q * q;
        if (m2 > lim * lim) begin
            mag = floor_sqrt(m2);
            d = scale_to_limit(d, lim, mag);
            q = scale_to_limit(q, lim, mag);
            vcmd = lim;
        end else begin
            vcmd = floor_sqrt(m2);
        end
        phase = {w.angle, {(32 - AW){1'b0}}};
        sn = sine_q15(phase);
        cs = sine_q15(phase + 32'h4000_0000);
        alpha = sat_volt(round_down(d * cs - q * sn, 15));
        beta = sat_volt(round_down(d * sn + q * cs, 15));
        ph[0] = alpha;
        ph[1] = sat_volt(round_down(-alpha * 16384 + 28378 * beta, 15));
        ph[2] = sat_volt(round_down(-alpha * 16384 - 28378 * beta, 15));
        if (filt_en) begin
            for (int i = 0; i < 3; i++) begin
                if (filt_seeded)
                    filt_y[i] = sat_volt(filt_y[i] + round_down(filt_k * (ph[i] - filt_y[i]), 16));
                else
                    filt_y[i] = ph[i];
                ph[i] = filt_y[i];
            end
            filt_seeded = 1;
        end else begin
            filt_seeded = 0;
        end
        r.pa = ph[0][VW-1:0];
        r.pb = ph[1][VW-1:0];
        r.pc = ph[2][VW-1:0];
        r.alpha = alpha[VW-1:0];
        r.beta = beta[VW-1:0];
        r.vcmd = vcmd[VW-2:0];
        r.zero = zero_en && (vcmd < zero_thr);
        r.direct = w.direct;
        return r;
    endfunction

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            failed = 1;
        end
    endfunction

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, longint value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[CW-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_LIMIT: lim_setting = value & 16'h7FFF;
            CFG_FILTER_EN: filt_en = value[0];
            CFG_FILTER_COEF: filt_k = value & 16'hFFFF;
            CFG_ZERO_EN: zero_en = value[0];
            CFG_ZERO_THR: zero_thr = value & 16'h7FFF;
            default: ;
        endcase
    endtask

    task automatic push_cmd(longint d, longint q, longint ang, longint bus, bit direct);
        t_cmd_word w;
        w.d = d[VW-1:0];
        w.q = q[VW-1:0];
        w.angle = ang[AW-1:0];
        w.bus = bus[VW-2:0];
        w.direct = direct;
        pending_cmds.push_back(w);
    endtask

    task automatic push_random_cmd();
        t_cmd_word w;
        w.d = $signed(VW'($urandom)) >>> $urandom_range(0, 9);
        w.q = $signed(VW'($urandom)) >>> $urandom_range(0, 9);
        w.angle = AW'($urandom);
        w.bus = ($urandom_range(0, 9) == 0) ? (VW - 1)'($urandom_range(0, 300))
                                            : (VW - 1)'($urandom);
        w.direct = 1'($urandom_range(0, 1));
        pending_cmds.push_back(w);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_cmds.size() != 0 || cmd_ch.valid || expected_phases.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb_dq_voltage_limit_inverse_park_clarke_core failed");
        $finish;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
            phase_ch.ready <= 1'b0;
        end else begin
            phase_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (!cmd_ch.valid || cmd_taken) begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    t_cmd_word w;
                    w = pending_cmds.pop_front();
                    cmd_ch.valid <= 1'b1;
                    cmd_ch.d_voltage <= w.d;
                    cmd_ch.q_voltage <= w.q;
                    cmd_ch.rotor_angle <= w.angle;
                    cmd_ch.bus_voltage <= w.bus;
                    cmd_ch.direct_path <= w.direct;
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
                cmd_taken = 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                t_cmd_word w;
                w.d = cmd_ch.d_voltage;
                w.q = cmd_ch.q_voltage;
                w.angle = cmd_ch.rotor_angle;
                w.bus = cmd_ch.bus_voltage;
                w.direct = cmd_ch.direct_path;
                expected_phases.push_back(predict_phases(w));
                cmd_taken = 1;
            end
            if (phase_ch.valid && phase_ch.ready) begin
                if (expected_phases.size() == 0) begin
                    $error("Result word arrived with no expectation pending");
                    failed = 1;
                end else begin
                    t_phase_word e;
                    e = expected_phases.pop_front();
                    check_field("phase_a_voltage", e.pa, phase_ch.phase_a_voltage);
                    check_field("phase_b_voltage", e.pb, phase_ch.phase_b_voltage);
                    check_field("phase_c_voltage", e.pc, phase_ch.phase_c_voltage);
                    check_field("alpha_voltage", e.alpha, phase_ch.alpha_voltage);
                    check_field("beta_voltage", e.beta, phase_ch.beta_voltage);
                    check_field("vector_magnitude", e.vcmd, phase_ch.vector_magnitude);
                    check_field("zero_vector", e.zero, phase_ch.zero_vector);
                    check_field("direct_path_echo", e.direct, phase_ch.direct_path_echo);
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_LIMIT;
        i_cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.d_voltage = '0;
        cmd_ch.q_voltage = '0;
        cmd_ch.rotor_angle = '0;
        cmd_ch.bus_voltage = '0;
        cmd_ch.direct_path = 1'b0;
        phase_ch.ready = 1'b0;
        cmd_taken = 0;
        failed = 0;
        send_idle_pct = 35;
        recv_idle_pct = 71;
        lim_setting = 0;
        filt_en = 0;
        filt_k = 65535;
        zero_en = 0;
        zero_thr = 0;
        filt_y = '{0, 0, 0};
        filt_seeded = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // A zero limit forces every nonzero vector to zero.
        push_cmd(12345, -2222, 1000, 32767, 1);
        push_cmd(0, 0, 0, 0, 0);
        wait_drained();

        write_reg(CFG_LIMIT, 32767);
        write_reg(CFG_ZERO_EN, 1);
        write_reg(CFG_ZERO_THR, 32767);
        write_reg(CFG_UNUSED_INDEX, 5);
        push_cmd(32767, 32767, 0, 32767, 1);
        push_cmd(-32768, -32768, 16384, 32767, 0);
        push_cmd(-32768, 32767, 32768, 32767, 1);
        push_cmd(32767, -32768, 49152, 32767, 0);
        push_cmd(32767, 0, 65535, 32767, 1);
        push_cmd(0, -32768, 8192, 32767, 0);
        push_cmd(1000, 2000, 12345, 0, 1);
        push_cmd(1000, 2000, 40000, 500, 0);
        push_cmd(300, -400, 21845, 500, 1);
        push_cmd(0, 0, 30000, 32767, 0);
        push_cmd(-1, 1, 1, 1, 1);
        push_cmd(20000, -20000, 24576, 16384, 0);
        wait_drained();

        write_reg(CFG_FILTER_EN, 1);
        write_reg(CFG_FILTER_COEF, 0);
        push_cmd(5000, 3000, 4000, 32767, 1);
        push_cmd(-5000, 3000, 20000, 32767, 0);
        push_cmd(32767, -32768, 60000, 32767, 1);
        wait_drained();
        write_reg(CFG_FILTER_COEF, 65535);
        push_cmd(-32768, -32768, 33000, 32767, 0);
        push_cmd(32767, 32767, 100, 32767, 1);
        push_cmd(100, -100, 50000, 32767, 0);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            send_idle_pct = (p < 2) ? 35 : (p < 4) ? 71 : 0;
            recv_idle_pct = (p < 2) ? 71 : (p < 4) ? 35 : 0;
            case (p)
                0: write_reg(CFG_LIMIT, $urandom_range(0, 32767));
                1: write_reg(CFG_LIMIT, 0);
                default: write_reg(CFG_LIMIT, (p % 2) ? 32767 : $urandom_range(500, 20000));
            endcase
            write_reg(CFG_FILTER_EN, p % 2 == 0);
            write_reg(CFG_FILTER_COEF, (p == 2) ? 0 : (p == 4) ? 65535 : $urandom_range(0, 65535));
            write_reg(CFG_ZERO_EN, p != 3);
            write_reg(CFG_ZERO_THR, (p == 5) ? 32767 : (p == 0) ? 0 : $urandom_range(0, 8000));
            for (int n = 0; n < PHASE_ITEMS; n++) push_random_cmd();
            wait_drained();
        end

        if (!failed)
            $display("tb_dq_voltage_limit_inverse_park_clarke_core passed");
        else
            $display("tb_dq_voltage_limit_inverse_park_clarke_core failed");
        $finish;
    end

endmodule
